### hw/rtl/pfl_pkg.sv
package pfl_pkg;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INIT  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_NO_MEM   = 2'd2
    } status_t;

    typedef enum logic {
        REG_REGION_START = 1'b0,
        REG_REGION_TOP   = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OWN,
        S_SCAN,
        S_POP,
        S_FCHK,
        S_FPUSH,
        S_INIT
    } state_t;

    typedef struct packed {
        logic latch;
        logic to_first;
        logic step_cur;
        logic rd_link;
        logic pop;
        logic push_free;
        logic init_start;
        logic init_step;
        logic fin_zero;
        logic fin_bad;
        logic fin_oom;
    } cmd_t;

    typedef struct packed {
        logic head_null;
        logic cur_last;
        logic init_more;
        logic free_bad;
    } sts_t;

endpackage

### hw/rtl/pfl_ram.sv
module pfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/pfl_ctrl.sv
module pfl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    action,
    output logic          busy,
    output pfl_pkg::cmd_t cmd,
    input  pfl_pkg::sts_t sts
);

    pfl_pkg::state_t state_reg;
    pfl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != pfl_pkg::S_IDLE);
        case (state_reg)
            pfl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    case (pfl_pkg::action_t'(action))
                        pfl_pkg::ACT_ALLOC: state_next = pfl_pkg::S_OWN;
                        pfl_pkg::ACT_FREE:  state_next = pfl_pkg::S_FCHK;
                        pfl_pkg::ACT_INIT:
                        begin
                            cmd.init_start = 1'b1;
                            state_next     = pfl_pkg::S_INIT;
                        end
                        default:            cmd.fin_zero = 1'b1;
                    endcase
                end
            end
            pfl_pkg::S_OWN:
            begin
                if (!sts.head_null)
                begin
                    cmd.rd_link = 1'b1;
                    state_next  = pfl_pkg::S_POP;
                end
                else
                begin
                    cmd.to_first = 1'b1;
                    state_next   = pfl_pkg::S_SCAN;
                end
            end
            pfl_pkg::S_SCAN:
            begin
                if (!sts.head_null)
                begin
                    cmd.rd_link = 1'b1;
                    state_next  = pfl_pkg::S_POP;
                end
                else if (sts.cur_last)
                begin
                    cmd.fin_oom = 1'b1;
                    state_next  = pfl_pkg::S_IDLE;
                end
                else
                begin
                    cmd.step_cur = 1'b1;
                end
            end
            pfl_pkg::S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = pfl_pkg::S_IDLE;
            end
            pfl_pkg::S_FCHK:
            begin
                state_next = pfl_pkg::S_FPUSH;
            end
            pfl_pkg::S_FPUSH:
            begin
                if (sts.free_bad)
                begin
                    cmd.fin_bad = 1'b1;
                end
                else
                begin
                    cmd.push_free = 1'b1;
                    cmd.fin_zero  = 1'b1;
                end
                state_next = pfl_pkg::S_IDLE;
            end
            pfl_pkg::S_INIT:
            begin
                if (sts.init_more)
                begin
                    cmd.init_step = 1'b1;
                end
                else
                begin
                    cmd.fin_zero = 1'b1;
                    state_next   = pfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/pfl_dp.sv
module pfl_dp #(
    parameter int NUM_CPUS   = 8,
    parameter int PAGE_SHIFT = 12,
    parameter int MAX_PAGES  = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [2:0]    cpu,
    input  logic [31:0]   page_addr,
    input  logic          cfg_wr,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  pfl_pkg::cmd_t cmd,
    output pfl_pkg::sts_t sts,
    output logic          done,
    output logic [1:0]    status,
    output logic [31:0]   page_addr_res,
    output logic [2:0]    source_cpu
);

    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int LINK_W = $clog2(MAX_PAGES + 1);
    localparam int CIDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int HI_W   = 33 - PAGE_SHIFT;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_PAGES);
    localparam logic [CIDX_W-1:0] LAST_CPU  = CIDX_W'(NUM_CPUS - 1);
    localparam logic [CIDX_W-1:0] INIT_CPU  = CIDX_W'((NUM_CPUS > 1) ? 1 : 0);
    localparam logic [33:0]       PAGE_B34  = 34'(1) << PAGE_SHIFT;
    localparam logic [32:0]       PAGE_M33  = (33'(1) << PAGE_SHIFT) - 33'(1);

    logic [31:0]       start_reg;
    logic [31:0]       top_reg;
    logic [32:0]       base_reg;
    logic [LINK_W-1:0] head_reg [NUM_CPUS];
    logic [CIDX_W-1:0] cur_reg;
    logic [31:0]       addr_reg;
    logic [IDX_W-1:0]  page_reg;
    logic [LINK_W-1:0] k_reg;
    logic [33:0]       pend_reg;
    logic              fbad_reg;
    logic [IDX_W-1:0]  fidx_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [31:0]       res_reg;
    logic [2:0]        src_reg;

    logic [LINK_W-1:0] head_cur;
    logic [LINK_W-1:0] link_rdata;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [2:0]        cpu_mod;
    logic [32:0]       fdiff;
    logic              fbad_next;
    logic [31:0]       pop_addr;
    logic [32:0]       start_up;

    always_comb
    begin
        cpu_mod = cpu;
        for (int i = 0; i < 8; i++)
        begin
            if (cpu_mod >= 3'(NUM_CPUS))
            begin
                cpu_mod = cpu_mod - 3'(NUM_CPUS);
            end
        end
    end

    assign head_cur = head_reg[cur_reg];
    assign start_up = {1'b0, cfg_data} + PAGE_M33;

    assign fdiff     = {1'b0, addr_reg} - base_reg;
    assign fbad_next = ((addr_reg & PAGE_M33[31:0]) != 32'd0)
                    || (addr_reg < start_reg)
                    || (addr_reg >= top_reg)
                    || (fdiff[32:PAGE_SHIFT] >= HI_W'(MAX_PAGES));

    assign pop_addr = base_reg[31:0] + (32'(page_reg) << PAGE_SHIFT);

    assign sts.head_null = (head_cur == NULL_LINK);
    assign sts.cur_last  = (cur_reg == LAST_CPU);
    assign sts.init_more = (k_reg < NULL_LINK) && (pend_reg <= {2'b00, top_reg});
    assign sts.free_bad  = fbad_reg;

    assign ram_we    = cmd.push_free || cmd.init_step;
    assign ram_waddr = cmd.push_free ? fidx_reg : k_reg[IDX_W-1:0];

    pfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (head_cur),
        .re    (cmd.rd_link),
        .raddr (head_cur[IDX_W-1:0]),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            top_reg   <= '0;
            base_reg  <= '0;
            done_reg  <= 1'b0;
            cur_reg   <= '0;
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                head_reg[c] <= NULL_LINK;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_index == pfl_pkg::REG_REGION_START)
                begin
                    start_reg <= cfg_data;
                    base_reg  <= start_up & ~PAGE_M33;
                end
                else
                begin
                    top_reg <= cfg_data;
                end
            end
            done_reg <= cmd.fin_zero || cmd.fin_bad || cmd.fin_oom || cmd.pop;
            if (cmd.latch)
            begin
                cur_reg <= CIDX_W'(cpu_mod);
            end
            if (cmd.to_first)
            begin
                cur_reg <= '0;
            end
            if (cmd.step_cur)
            begin
                cur_reg <= cur_reg + CIDX_W'(1);
            end
            if (cmd.init_start)
            begin
                cur_reg <= INIT_CPU;
                for (int c = 0; c < NUM_CPUS; c++)
                begin
                    head_reg[c] <= NULL_LINK;
                end
            end
            if (cmd.init_step)
            begin
                cur_reg <= (cur_reg == LAST_CPU) ? '0 : cur_reg + CIDX_W'(1);
                head_reg[cur_reg] <= k_reg;
            end
            if (cmd.push_free)
            begin
                head_reg[cur_reg] <= LINK_W'(fidx_reg);
            end
            if (cmd.pop)
            begin
                head_reg[cur_reg] <= link_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fbad_reg <= fbad_next;
        fidx_reg <= fdiff[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];
        if (cmd.latch)
        begin
            addr_reg <= page_addr;
        end
        if (cmd.rd_link)
        begin
            page_reg <= head_cur[IDX_W-1:0];
        end
        if (cmd.init_start)
        begin
            k_reg    <= '0;
            pend_reg <= {1'b0, base_reg} + PAGE_B34;
        end
        if (cmd.init_step)
        begin
            k_reg    <= k_reg + LINK_W'(1);
            pend_reg <= pend_reg + PAGE_B34;
        end
        if (cmd.fin_zero)
        begin
            status_reg <= pfl_pkg::ST_OK;
            res_reg    <= '0;
            src_reg    <= '0;
        end
        if (cmd.fin_bad)
        begin
            status_reg <= pfl_pkg::ST_BAD_ADDR;
            res_reg    <= '0;
            src_reg    <= '0;
        end
        if (cmd.fin_oom)
        begin
            status_reg <= pfl_pkg::ST_NO_MEM;
            res_reg    <= '0;
            src_reg    <= '0;
        end
        if (cmd.pop)
        begin
            status_reg <= pfl_pkg::ST_OK;
            res_reg    <= pop_addr;
            src_reg    <= 3'(cur_reg);
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign page_addr_res = res_reg;
    assign source_cpu    = src_reg;

endmodule

### hw/rtl/per_cpu_page_free_list_allocator.sv
// Alloc from own list: the start cycle, S_OWN and S_POP, then the registered result strobe;
//   stealing adds S_SCAN, which steps through the lists one at a time. Free: S_FCHK, S_FPUSH.
// Unused action: finished from idle. Init: one page pushed per cycle through the single
//   link-table write port. One request at a time; a new start is taken once busy drops.
// The receiver cannot stall: done is a one-cycle strobe.
// Reset (rst_n low, asynchronous) empties every list and clears both region registers.
module per_cpu_page_free_list_allocator #(
    parameter int NUM_CPUS   = 8,
    parameter int PAGE_SHIFT = 12,
    parameter int MAX_PAGES  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [2:0]  cpu,
    input  logic [31:0] page_addr,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] page_addr_res,
    output logic [2:0]  source_cpu,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    pfl_pkg::cmd_t cmd;
    pfl_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pfl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd),
        .sts    (sts)
    );

    pfl_dp #(
        .NUM_CPUS   (NUM_CPUS),
        .PAGE_SHIFT (PAGE_SHIFT),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cpu           (cpu),
        .page_addr     (page_addr),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .done          (done),
        .status        (status),
        .page_addr_res (page_addr_res),
        .source_cpu    (source_cpu)
    );

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCPU   = 8;
    localparam int PSHIFT = 12;
    localparam int NPAGES = 1024;
    localparam logic [10:0] LINK_NULL = 11'(NPAGES);

    typedef struct {
        pfl_pkg::status_t status;
        logic [31:0]      addr;
        logic [2:0]       src;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = pfl_pkg::ACT_NONE;
    logic [2:0]  cpu = 3'd0;
    logic [31:0] page_addr = 32'd0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] page_addr_res;
    logic [2:0]  source_cpu;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = pfl_pkg::REG_REGION_START;
    logic [31:0] cfg_data = 32'd0;

    logic [10:0] link_tbl [NPAGES];
    logic [10:0] head_tbl [NCPU];
    logic [31:0] reg_start;
    logic [31:0] reg_top;

    alloc_result_t pending_results[$];
    int            held_pages[$];
    int            errors = 0;
    bit            steady = 1'b0;

    per_cpu_page_free_list_allocator #(
        .NUM_CPUS   (NCPU),
        .PAGE_SHIFT (PSHIFT),
        .MAX_PAGES  (NPAGES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .cpu           (cpu),
        .page_addr     (page_addr),
        .done          (done),
        .status        (status),
        .page_addr_res (page_addr_res),
        .source_cpu    (source_cpu),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [63:0] region_base();
        return ({32'd0, reg_start} + 64'hFFF) & ~64'hFFF;
    endfunction

    function automatic void push_page(int pg, int c);
        link_tbl[pg] = head_tbl[c];
        head_tbl[c]  = 11'(pg);
    endfunction

    function automatic bit pop_page(int c, output logic [10:0] pg);
        pg = head_tbl[c];
        if (pg >= LINK_NULL)
            return 1'b0;
        head_tbl[c] = link_tbl[pg];
        return 1'b1;
    endfunction

    function automatic alloc_result_t predict_request(pfl_pkg::action_t act, logic [2:0] c_in,
                                                      logic [31:0] addr,
                                                      output int taken_page);
        alloc_result_t r;
        logic [63:0]   base;
        logic [63:0]   idx;
        logic [10:0]   pg;
        int            c;
        int            k;
        bit            got;
        r.status   = pfl_pkg::ST_OK;
        r.addr     = 32'd0;
        r.src      = 3'd0;
        taken_page = -1;
        c          = int'(c_in) % NCPU;
        base       = region_base();
        case (act)
            pfl_pkg::ACT_INIT:
            begin
                for (k = 0; k < NCPU; k++)
                    head_tbl[k] = LINK_NULL;
                k = 0;
                while (k < NPAGES && base + ((64'(k) + 64'd1) << PSHIFT) <= {32'd0, reg_top})
                begin
                    push_page(k, (k + 1) % NCPU);
                    k++;
                end
            end
            pfl_pkg::ACT_FREE:
            begin
                if (addr[PSHIFT-1:0] != '0 || addr < reg_start || addr >= reg_top)
                    r.status = pfl_pkg::ST_BAD_ADDR;
                else
                begin
                    idx = ({32'd0, addr} - base) >> PSHIFT;
                    if (idx >= NPAGES)
                        r.status = pfl_pkg::ST_BAD_ADDR;
                    else
                        push_page(int'(idx), c);
                end
            end
            pfl_pkg::ACT_ALLOC:
            begin
                got   = pop_page(c, pg);
                r.src = 3'(c);
                for (k = 0; k < NCPU && !got; k++)
                begin
                    if (k != c)
                    begin
                        got = pop_page(k, pg);
                        if (got)
                            r.src = 3'(k);
                    end
                end
                if (got)
                begin
                    r.addr     = 32'(base + (64'(pg) << PSHIFT));
                    taken_page = int'(pg);
                end
                else
                begin
                    r.status = pfl_pkg::ST_NO_MEM;
                    r.src    = 3'd0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unrequested result: status %0d addr %h src %0d",
                             status, page_addr_res, source_cpu);
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status || page_addr_res !== e.addr || source_cpu !== e.src)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: status %0d/%0d addr %h/%h src %0d/%0d (exp/act)",
                                 e.status, status, e.addr, page_addr_res, e.src, source_cpu);
                end
            end
        end
    end

    task automatic send_request(input pfl_pkg::action_t act, input logic [2:0] c,
                                input logic [31:0] addr);
        alloc_result_t r;
        int            gap;
        int            pg;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 26)
                gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        cpu       <= c;
        page_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_request(act, c, addr, pg);
        pending_results.push_back(r);
        if (act == pfl_pkg::ACT_INIT)
            held_pages.delete();
        if (pg >= 0)
            held_pages.push_back(pg);
    endtask

    // hold off new requests until every result is back and the block is idle
    task automatic wait_all_returned();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_region(input logic [31:0] lo, input logic [31:0] hi);
        wait_all_returned();
        cfg_valid <= 1'b1;
        cfg_index <= pfl_pkg::REG_REGION_START;
        cfg_data  <= lo;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_start = lo;
        cfg_index <= pfl_pkg::REG_REGION_TOP;
        cfg_data  <= hi;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_top = hi;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_after_reset();
        send_request(pfl_pkg::ACT_ALLOC, 3'd0, 32'h0000_0000);
        send_request(pfl_pkg::ACT_FREE, 3'd3, 32'h0000_0000);
        send_request(pfl_pkg::ACT_NONE, 3'd7, 32'hFFFF_FFFF);
        send_request(pfl_pkg::ACT_INIT, 3'd5, 32'hFFFF_F000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd7, 32'hFFFF_FFFF);
    endtask

    task automatic test_small_region();
        write_region(32'h0000_1001, 32'h0000_5800);
        send_request(pfl_pkg::ACT_INIT, 3'd0, 32'h0000_0000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd1, 32'h0000_0000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd1, 32'h0000_0000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd6, 32'h0000_0000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd0, 32'h0000_0000);
        send_request(pfl_pkg::ACT_FREE, 3'd5, 32'h0000_5000);
        send_request(pfl_pkg::ACT_FREE, 3'd5, 32'h0000_2001);
        send_request(pfl_pkg::ACT_FREE, 3'd5, 32'h0000_1000);
        send_request(pfl_pkg::ACT_FREE, 3'd5, 32'h0000_6000);
        send_request(pfl_pkg::ACT_FREE, 3'd4, 32'h0000_3000);
        send_request(pfl_pkg::ACT_FREE, 3'd4, 32'h0000_3000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd4, 32'h0000_0000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd4, 32'h0000_0000);
    endtask

    task automatic test_region_moves();
        write_region(32'h0000_0000, 32'h0000_4000);
        send_request(pfl_pkg::ACT_INIT, 3'd2, 32'h0000_0000);
        write_region(32'hFFFF_F001, 32'h0000_4000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd1, 32'h0000_0000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd2, 32'h0000_0000);
        write_region(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(pfl_pkg::ACT_FREE, 3'd0, 32'h0040_0000);
        send_request(pfl_pkg::ACT_INIT, 3'd0, 32'h0000_0000);
        send_request(pfl_pkg::ACT_ALLOC, 3'd0, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] addr;
        logic [63:0] base;
        logic [63:0] span;
        int          sent;
        int          ph;
        int          n_items;
        int          i;
        int          r;
        int          j;
        sent = 0;
        ph   = 0;
        while (sent < 1900)
        begin
            n_items = 250;
            case (ph % 8)
                0:
                begin
                    lo = 32'h8000_0123;
                    hi = 32'h8001_4800;
                end
                1:
                begin
                    lo = $urandom;
                    hi = lo + (32'($urandom_range(0, 64)) << PSHIFT) + 32'($urandom_range(0, 4095));
                end
                2:
                begin
                    lo      = 32'h0000_0000;
                    hi      = 32'hFFFF_FFFF;
                    n_items = 150;
                end
                3:
                begin
                    lo      = 32'hFFFF_E000;
                    hi      = 32'hFFFF_FFFF;
                    n_items = 40;
                end
                4:
                begin
                    lo      = 32'h1000_0000;
                    hi      = 32'h0800_0000;
                    n_items = 40;
                end
                5:
                begin
                    lo = $urandom;
                    hi = lo + (32'($urandom_range(1, 12)) << PSHIFT);
                end
                6:
                begin
                    lo      = 32'hFFFF_FFFF;
                    hi      = 32'hFFFF_FFFF;
                    n_items = 40;
                end
                default:
                begin
                    lo      = 32'h0000_0000;
                    hi      = 32'h0000_0000;
                    n_items = 40;
                end
            endcase
            write_region(lo, hi);
            steady = (ph % 8 == 1);
            if (ph == 0 || $urandom_range(3) != 0)
            begin
                send_request(pfl_pkg::ACT_INIT, 3'($urandom_range(0, 7)), $urandom);
                sent++;
            end
            base = region_base();
            span = ({32'd0, reg_top} > base) ? (({32'd0, reg_top} - base) >> PSHIFT) : 64'd0;
            if (span > NPAGES + 4)
                span = NPAGES + 4;
            for (i = 0; i < n_items; i++)
            begin
                r = $urandom_range(99);
                if (r >= 42 && r < 72 && held_pages.size() != 0)
                begin
                    j    = $urandom_range(0, held_pages.size() - 1);
                    addr = 32'(base + (64'(held_pages[j]) << PSHIFT));
                    held_pages.delete(j);
                    send_request(pfl_pkg::ACT_FREE, 3'($urandom_range(0, 7)), addr);
                end
                else if (r >= 72 && r < 82)
                begin
                    addr = 32'(base + (64'($urandom_range(0, int'(span) + 2)) << PSHIFT));
                    send_request(pfl_pkg::ACT_FREE, 3'($urandom_range(0, 7)), addr);
                end
                else if (r >= 82 && r < 86)
                    send_request(pfl_pkg::ACT_FREE, 3'($urandom_range(0, 7)), $urandom);
                else if (r >= 86 && r < 90)
                begin
                    addr = 32'(base) + 32'($urandom_range(1, 4095));
                    send_request(pfl_pkg::ACT_FREE, 3'($urandom_range(0, 7)), addr);
                end
                else if (r >= 90 && r < 94)
                    send_request(pfl_pkg::ACT_NONE, 3'($urandom_range(0, 7)), $urandom);
                else if (r >= 94 && r < 97)
                    send_request(pfl_pkg::ACT_INIT, 3'($urandom_range(0, 7)), $urandom);
                else
                    send_request(pfl_pkg::ACT_ALLOC, 3'($urandom_range(0, 7)), $urandom);
                sent++;
            end
            ph++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        for (int k = 0; k < NCPU; k++)
            head_tbl[k] = LINK_NULL;
        for (int k = 0; k < NPAGES; k++)
            link_tbl[k] = '0;
        reg_start = 32'd0;
        reg_top   = 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_after_reset();
        test_small_region();
        test_region_moves();
        test_random_traffic();
        wait_all_returned();
        repeat (NCPU + 8) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pfl_pkg.sv
hw/rtl/pfl_ram.sv
hw/rtl/pfl_ctrl.sv
hw/rtl/pfl_dp.sv
hw/rtl/per_cpu_page_free_list_allocator.sv
tb/testbench.sv
